[hdl/ffa_pkg.sv]
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int PAGE_UNITS = 256;
  localparam int MAX_PAGES  = 4;
  localparam int HEAP_UNITS = MAX_PAGES * PAGE_UNITS;
  localparam int ADDR_W     = $clog2(HEAP_UNITS);
  localparam int UNIT_W     = ADDR_W + 1;
  localparam int MAX_REQUEST = HEAP_UNITS * 16 - 16;

  localparam logic [UNIT_W-1:0] NIL_UNIT = UNIT_W'(HEAP_UNITS);

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NO_MEM  = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // One tag entry per unit: header, footer and list links.
  typedef struct packed {
    logic              ha;
    logic [UNIT_W-1:0] hs;
    logic [3:0]        hp;
    logic              fa;
    logic [UNIT_W-1:0] fs;
    logic [UNIT_W-1:0] nx;
    logic [UNIT_W-1:0] pv;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  // Free payload bytes of a block of s units.
  function automatic logic [14:0] free_bytes(input logic [UNIT_W-1:0] s);
    logic [14:0] b;
    b = 15'({s, 4'b0000});
    return b - 15'd16;
  endfunction

endpackage

[hdl/ffa_ram.sv]
`timescale 1ns / 1ps
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

endmodule

[hdl/first_fit_free_list_allocator_unit.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   kind, request_bytes, block_address
// out      output     out_valid / out_ready status, payload_address, stats
//
// Every tag write is a read of the tag memory, answered in the next cycle, and then
// the write-back. The first-fit walk visits each free-list entry in a search state
// and a check state; unlinking one block reads its links, then rewrites the next
// link of its predecessor (or the list head) and the back link of any successor.
// Each added page is released onto the list and the walk restarts from the head;
// a reallocate releases the old block after the new one is allocated. Reset
// (synchronous, active low) empties the list and clears all totals; the tag
// memory is not cleared. A result waits in the output register while out_ready
// is low; the next item is taken once the sequencer is idle again.
module first_fit_free_list_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_request_bytes,
  input  logic [13:0] in_block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [13:0] out_payload_address,
  output logic [14:0] out_internal_bytes,
  output logic [14:0] out_external_bytes,
  output logic [31:0] out_allocation_count,
  output logic [31:0] out_free_count,
  output logic [31:0] out_coalesce_count
);

  localparam int UW = ffa_pkg::UNIT_W;
  localparam int AW = ffa_pkg::ADDR_W;

  localparam logic [5:0] S_IDLE = 6'd0, S_START = 6'd1, S_A_CHK = 6'd2, S_A_INIT = 6'd3,
    S_A_SRCH = 6'd4, S_A_SRCH_Q = 6'd5, S_A_TAKE = 6'd6, S_A_TAKE_W = 6'd7,
    S_A_FTR_R = 6'd8, S_A_FTR_W = 6'd9, S_A_OK = 6'd10, S_A_GROW = 6'd11,
    S_F_RD = 6'd12, S_F_Q = 6'd13, S_F_FTR_R = 6'd14, S_F_FTR_W = 6'd15,
    S_F_END = 6'd16, S_R_BEGIN = 6'd17, S_R_LQ = 6'd18, S_R_LMRG = 6'd19,
    S_R_LW1 = 6'd20, S_R_LR2 = 6'd21, S_R_LW2 = 6'd22, S_R_RCHK = 6'd23,
    S_R_RQ = 6'd24, S_R_RMRG = 6'd25, S_R_RW1 = 6'd26, S_R_RR2 = 6'd27,
    S_R_RW2 = 6'd28, S_R_FIN = 6'd29, S_R_FIN_W = 6'd30, S_R_FTR_R = 6'd31,
    S_R_FTR_W = 6'd32, S_R_HEAD = 6'd33, S_R_HEAD_W = 6'd34, S_R_END = 6'd35,
    S_L_RD = 6'd36, S_L_Q = 6'd37, S_L_P_R = 6'd38, S_L_P_W = 6'd39,
    S_L_N = 6'd40, S_L_N_W = 6'd41, S_DONE = 6'd42;

  logic [5:0]  state_r, state_nxt, lret_r, lret_nxt, rret_r, rret_nxt;
  logic [1:0]  kind_r, kind_nxt, stat_r, stat_nxt;
  logic [15:0] size_r, size_nxt;
  logic [13:0] baddr_r, baddr_nxt, res_r, res_nxt;
  logic [3:0]  pad_r, pad_nxt;
  logic [UW-1:0] need_r, need_nxt, b_r, b_nxt, bs_r, bs_nxt, steps_r, steps_nxt;
  logic [UW-1:0] head_r, head_nxt, ru_r, ru_nxt, rs_r, rs_nxt, rstart_r, rstart_nxt;
  logic [UW-1:0] ps_r, ps_nxt, lb_r, lb_nxt, lp_r, lp_nxt, ln_r, ln_nxt;
  logic [UW:0]   rend_r, rend_nxt;
  logic          merged_r, merged_nxt;
  logic [2:0]  pages_r, pages_nxt;
  logic [14:0] int_r, int_nxt, ext_r, ext_nxt;
  logic [31:0] acnt_r, acnt_nxt, fcnt_r, fcnt_nxt, ccnt_r, ccnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          out_valid_r;

  logic          ram_we;
  ffa_pkg::tag_t q, w;

  logic [UW-1:0] top;
  logic [3:0]    pad_c;
  logic [16:0]   sum_c;
  logic          load_out;

  assign top   = UW'(pages_r) * UW'(ffa_pkg::PAGE_UNITS);
  assign pad_c = 4'd0 - size_r[3:0];
  assign sum_c = {1'b0, size_r} + {13'b0, pad_c};

  ffa_ram #(.WIDTH(ffa_pkg::TAG_W), .DEPTH(ffa_pkg::HEAP_UNITS)) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (w),
    .raddr (addr_nxt),
    .q     (q)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;  lret_nxt = lret_r;  rret_nxt = rret_r;
    kind_nxt = kind_r;  stat_nxt = stat_r;  size_nxt = size_r;  baddr_nxt = baddr_r;
    res_nxt = res_r;  pad_nxt = pad_r;  need_nxt = need_r;  b_nxt = b_r;  bs_nxt = bs_r;
    steps_nxt = steps_r;  head_nxt = head_r;  ru_nxt = ru_r;  rs_nxt = rs_r;
    rstart_nxt = rstart_r;  ps_nxt = ps_r;  lb_nxt = lb_r;  lp_nxt = lp_r;  ln_nxt = ln_r;
    rend_nxt = rend_r;  merged_nxt = merged_r;  pages_nxt = pages_r;
    int_nxt = int_r;  ext_nxt = ext_r;  acnt_nxt = acnt_r;  fcnt_nxt = fcnt_r;
    ccnt_nxt = ccnt_r;  addr_nxt = addr_r;
    ram_we = 1'b0;  w = q;  load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;  size_nxt = in_request_bytes;  baddr_nxt = in_block_address;
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_nxt = '0;
        stat_nxt = ffa_pkg::ST_OK;
        case (kind_r)
          ffa_pkg::KIND_ALLOC, ffa_pkg::KIND_REALLOC: state_nxt = S_A_CHK;
          ffa_pkg::KIND_FREE: state_nxt = S_F_RD;
          default: begin
            stat_nxt = ffa_pkg::ST_INVALID;  state_nxt = S_DONE;
          end
        endcase
      end
      // Allocate: size checks, first-fit walk, grow.
      S_A_CHK: begin
        pad_nxt = pad_c;
        need_nxt = UW'(sum_c[16:4]) + UW'(1);
        if (size_r == 16'd0) begin
          stat_nxt = ffa_pkg::ST_INVALID;  state_nxt = S_DONE;
        end else if (32'(size_r) > 32'(ffa_pkg::MAX_REQUEST)) begin
          stat_nxt = ffa_pkg::ST_NO_MEM;  state_nxt = S_DONE;
        end else begin
          state_nxt = S_A_INIT;
        end
      end
      S_A_INIT: begin
        b_nxt = head_r;  steps_nxt = '0;  state_nxt = S_A_SRCH;
      end
      S_A_SRCH: begin
        if (b_r < ffa_pkg::NIL_UNIT && steps_r < ffa_pkg::NIL_UNIT) begin
          addr_nxt = b_r[AW-1:0];  state_nxt = S_A_SRCH_Q;
        end else begin
          state_nxt = S_A_GROW;
        end
      end
      S_A_SRCH_Q: begin
        if (q.hs != '0 && ({1'b0, b_r} + {1'b0, q.hs}) <= {1'b0, top} &&
            ({1'b0, q.hs} >= {1'b0, need_r} + (UW+1)'(2) || q.hs == need_r)) begin
          bs_nxt = q.hs;  lb_nxt = b_r;  lret_nxt = S_A_TAKE;  state_nxt = S_L_RD;
        end else begin
          b_nxt = q.nx;  steps_nxt = steps_r + UW'(1);  state_nxt = S_A_SRCH;
        end
      end
      S_A_TAKE: begin
        ext_nxt = ext_r - ffa_pkg::free_bytes(bs_r);
        addr_nxt = b_r[AW-1:0];  state_nxt = S_A_TAKE_W;
      end
      S_A_TAKE_W: begin
        w.ha = 1'b1;  w.hs = need_r;  w.hp = pad_r;  ram_we = 1'b1;
        state_nxt = S_A_FTR_R;
      end
      S_A_FTR_R: begin
        addr_nxt = AW'(b_r + need_r - UW'(1));  state_nxt = S_A_FTR_W;
      end
      S_A_FTR_W: begin
        w.fa = 1'b1;  w.fs = need_r;  ram_we = 1'b1;
        int_nxt = int_r + 15'(pad_r) + 15'd16;
        acnt_nxt = acnt_r + 32'd1;
        res_nxt = {b_r[AW-1:0], 4'b1000};
        if (bs_r != need_r) begin
          ru_nxt = b_r + need_r;  rs_nxt = bs_r - need_r;  rret_nxt = S_A_OK;
          state_nxt = S_R_BEGIN;
        end else begin
          state_nxt = S_A_OK;
        end
      end
      S_A_OK: begin
        state_nxt = (kind_r == ffa_pkg::KIND_REALLOC) ? S_F_RD : S_DONE;
      end
      S_A_GROW: begin
        if (32'(pages_r) >= 32'(ffa_pkg::MAX_PAGES)) begin
          stat_nxt = ffa_pkg::ST_NO_MEM;  state_nxt = S_DONE;
        end else begin
          pages_nxt = pages_r + 3'd1;
          ru_nxt = top;  rs_nxt = UW'(ffa_pkg::PAGE_UNITS);  rret_nxt = S_A_INIT;
          state_nxt = S_R_BEGIN;
        end
      end
      // Free: validate the header, clear alloc bits, release.
      S_F_RD: begin
        if (baddr_r[3:0] != 4'b1000 || {1'b0, baddr_r[13:4]} >= top) begin
          if (kind_r == ffa_pkg::KIND_FREE) stat_nxt = ffa_pkg::ST_IGNORED;
          state_nxt = S_DONE;
        end else begin
          addr_nxt = baddr_r[13:4];  state_nxt = S_F_Q;
        end
      end
      S_F_Q: begin
        if (!q.ha || q.hs < UW'(2) ||
            ({2'b0, baddr_r[13:4]} + {1'b0, q.hs}) > {1'b0, top}) begin
          if (kind_r == ffa_pkg::KIND_FREE) stat_nxt = ffa_pkg::ST_IGNORED;
          state_nxt = S_DONE;
        end else begin
          int_nxt = int_r - (15'(q.hp) + 15'd16);
          w.ha = 1'b0;  ram_we = 1'b1;
          ru_nxt = {1'b0, baddr_r[13:4]};  rs_nxt = q.hs;
          state_nxt = S_F_FTR_R;
        end
      end
      S_F_FTR_R: begin
        addr_nxt = AW'(ru_r + rs_r - UW'(1));  state_nxt = S_F_FTR_W;
      end
      S_F_FTR_W: begin
        w.fa = 1'b0;  ram_we = 1'b1;
        rret_nxt = S_F_END;  state_nxt = S_R_BEGIN;
      end
      S_F_END: state_nxt = S_DONE;
      // Release a run of units: merge left, merge right, push at the head.
      S_R_BEGIN: begin
        rstart_nxt = ru_r;  merged_nxt = 1'b0;  rend_nxt = {1'b0, ru_r} + {1'b0, rs_r};
        if (ru_r != '0 && (ru_r - UW'(1)) < top) begin
          addr_nxt = AW'(ru_r - UW'(1));  state_nxt = S_R_LQ;
        end else begin
          state_nxt = S_R_RCHK;
        end
      end
      S_R_LQ: begin
        if (!q.fa && q.fs != '0 && q.fs <= ru_r) begin
          ps_nxt = q.fs;  rstart_nxt = ru_r - q.fs;  lb_nxt = ru_r - q.fs;
          lret_nxt = S_R_LMRG;  state_nxt = S_L_RD;
        end else begin
          state_nxt = S_R_RCHK;
        end
      end
      S_R_LMRG: begin
        ext_nxt = ext_r - ffa_pkg::free_bytes(ps_r);
        addr_nxt = AW'(ru_r - UW'(1));  state_nxt = S_R_LW1;
      end
      S_R_LW1: begin
        w.fa = 1'b0;  w.fs = '0;  ram_we = 1'b1;  state_nxt = S_R_LR2;
      end
      S_R_LR2: begin
        addr_nxt = ru_r[AW-1:0];  state_nxt = S_R_LW2;
      end
      S_R_LW2: begin
        w.ha = 1'b0;  w.hs = '0;  w.hp = '0;  ram_we = 1'b1;
        rs_nxt = rs_r + ps_r;  merged_nxt = 1'b1;  state_nxt = S_R_RCHK;
      end
      S_R_RCHK: begin
        if (rend_r < {1'b0, top}) begin
          addr_nxt = rend_r[AW-1:0];  state_nxt = S_R_RQ;
        end else begin
          state_nxt = S_R_FIN;
        end
      end
      S_R_RQ: begin
        if (!q.ha && q.hs != '0 && (rend_r + {1'b0, q.hs}) <= {1'b0, top}) begin
          ps_nxt = q.hs;  lb_nxt = rend_r[UW-1:0];
          lret_nxt = S_R_RMRG;  state_nxt = S_L_RD;
        end else begin
          state_nxt = S_R_FIN;
        end
      end
      S_R_RMRG: begin
        ext_nxt = ext_r - ffa_pkg::free_bytes(ps_r);
        addr_nxt = AW'(rend_r - (UW+1)'(1));  state_nxt = S_R_RW1;
      end
      S_R_RW1: begin
        w.fa = 1'b0;  w.fs = '0;  ram_we = 1'b1;  state_nxt = S_R_RR2;
      end
      S_R_RR2: begin
        addr_nxt = rend_r[AW-1:0];  state_nxt = S_R_RW2;
      end
      S_R_RW2: begin
        w.ha = 1'b0;  w.hs = '0;  w.hp = '0;  ram_we = 1'b1;
        rs_nxt = rs_r + ps_r;  merged_nxt = 1'b1;  state_nxt = S_R_FIN;
      end
      S_R_FIN: begin
        addr_nxt = rstart_r[AW-1:0];  state_nxt = S_R_FIN_W;
      end
      S_R_FIN_W: begin
        w.ha = 1'b0;  w.hs = rs_r;  w.hp = '0;  w.pv = ffa_pkg::NIL_UNIT;  w.nx = head_r;
        ram_we = 1'b1;  state_nxt = S_R_FTR_R;
      end
      S_R_FTR_R: begin
        addr_nxt = AW'(rstart_r + rs_r - UW'(1));  state_nxt = S_R_FTR_W;
      end
      S_R_FTR_W: begin
        w.fa = 1'b0;  w.fs = rs_r;  ram_we = 1'b1;  state_nxt = S_R_HEAD;
      end
      S_R_HEAD: begin
        if (head_r < ffa_pkg::NIL_UNIT) begin
          addr_nxt = head_r[AW-1:0];  state_nxt = S_R_HEAD_W;
        end else begin
          state_nxt = S_R_END;
        end
      end
      S_R_HEAD_W: begin
        w.pv = rstart_r;  ram_we = 1'b1;  state_nxt = S_R_END;
      end
      S_R_END: begin
        head_nxt = rstart_r;
        ext_nxt = ext_r + ffa_pkg::free_bytes(rs_r);
        fcnt_nxt = fcnt_r + 32'd1;
        ccnt_nxt = ccnt_r + 32'(merged_r);
        state_nxt = rret_r;
      end
      // Unlink one block from the list.
      S_L_RD: begin
        addr_nxt = lb_r[AW-1:0];  state_nxt = S_L_Q;
      end
      S_L_Q: begin
        lp_nxt = q.pv;  ln_nxt = q.nx;
        if (q.pv < ffa_pkg::NIL_UNIT) begin
          state_nxt = S_L_P_R;
        end else begin
          head_nxt = q.nx;  state_nxt = S_L_N;
        end
      end
      S_L_P_R: begin
        addr_nxt = lp_r[AW-1:0];  state_nxt = S_L_P_W;
      end
      S_L_P_W: begin
        w.nx = ln_r;  ram_we = 1'b1;  state_nxt = S_L_N;
      end
      S_L_N: begin
        if (ln_r < ffa_pkg::NIL_UNIT) begin
          addr_nxt = ln_r[AW-1:0];  state_nxt = S_L_N_W;
        end else begin
          state_nxt = lret_r;
        end
      end
      S_L_N_W: begin
        w.pv = lp_r;  ram_we = 1'b1;  state_nxt = lret_r;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;  state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= ffa_pkg::NIL_UNIT;
      pages_r <= '0;
      int_r <= '0;  ext_r <= '0;
      acnt_r <= '0;  fcnt_r <= '0;  ccnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      pages_r <= pages_nxt;
      int_r <= int_nxt;  ext_r <= ext_nxt;
      acnt_r <= acnt_nxt;  fcnt_r <= fcnt_nxt;  ccnt_r <= ccnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working payload: no reset needed.
  always_ff @(posedge clk) begin
    lret_r <= lret_nxt;  rret_r <= rret_nxt;  kind_r <= kind_nxt;  stat_r <= stat_nxt;
    size_r <= size_nxt;  baddr_r <= baddr_nxt;  res_r <= res_nxt;  pad_r <= pad_nxt;
    need_r <= need_nxt;  b_r <= b_nxt;  bs_r <= bs_nxt;  steps_r <= steps_nxt;
    ru_r <= ru_nxt;  rs_r <= rs_nxt;  rstart_r <= rstart_nxt;  ps_r <= ps_nxt;
    lb_r <= lb_nxt;  lp_r <= lp_nxt;  ln_r <= ln_nxt;  rend_r <= rend_nxt;
    merged_r <= merged_nxt;  addr_r <= addr_nxt;
    if (load_out) begin
      out_status <= stat_r;
      out_payload_address <= (stat_r == ffa_pkg::ST_OK) ? res_r : 14'd0;
      out_internal_bytes <= int_r;
      out_external_bytes <= ext_r;
      out_allocation_count <= acnt_r;
      out_free_count <= fcnt_r;
      out_coalesce_count <= ccnt_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_head_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    head_r == ffa_pkg::NIL_UNIT || head_r < top)
    else $error("free list head outside heap");
  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pages_r) <= 32'(ffa_pkg::MAX_PAGES))
    else $error("page count beyond limit");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE && !load_out)
    else $error("accepted item not started");
`endif

endmodule
